// File: sv/qbt_pkg.sv
// qbt_pkg: shared constants, defaults and the result type of the quote/brace tokenizer
// used by every module of the block; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package qbt_pkg;

  localparam int LINE_MAX_DEFAULT    = 128;
  localparam int TOKEN_SLOTS_DEFAULT = 32;

  localparam logic [5:0] MAX_TOKENS_RESET = 6'd32;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;

  localparam logic signed [4:0] DEPTH_MAX = 5'sd15;
  localparam logic signed [4:0] DEPTH_MIN = -5'sd16;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       token_start;
    logic [7:0] token_position;
    logic [4:0] token_slot;
    logic       table_full;
  } qbt_result_t;

endpackage

`default_nettype wire

// File: sv/qbt_if.sv
// qbt_if: valid/ready channel interfaces for input items, result items and the config write
// depends on nothing; field widths follow the block's item layout
`timescale 1ns / 1ps
`default_nettype none

interface qbt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       end_of_line;

  modport source (output valid, char_in, end_of_line, input ready);
  modport sink   (input valid, char_in, end_of_line, output ready);
endinterface

interface qbt_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       token_start;
  logic [7:0] token_position;
  logic [4:0] token_slot;
  logic       table_full;

  modport source (output valid, out_byte, token_start, token_position, token_slot,
                  table_full, input ready);
  modport sink   (input valid, out_byte, token_start, token_position, token_slot,
                  table_full, output ready);
endinterface

interface qbt_cfg_if;
  logic       valid;
  logic       ready;
  logic [5:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

// File: sv/quote_brace_tokenizer_top.sv
// quote_brace_tokenizer_top: command line tokenizer, input register, step logic, result register
// depends on qbt_pkg, qbt_if (channel interfaces) and qbt_step
//
// Usage:
//   din carries one byte of a command line per item, with end_of_line on the last byte.
//   dout returns exactly one result item per input item, in order: the byte (or zero
//   where it ends a token), a token start mark with its line offset and slot, and a
//   flag when a start was dropped because all slots were taken.
//   cfg writes max_tokens (the number of usable slots); write it only while idle.
// Timing:
//   an item passes the input register, then the result register, before its result
//   shows on dout; one item per cycle sustained while dout keeps taking results,
//   since the line state update is a single short step between the two registers.
// Reset:
//   rst clears both pipeline registers, the line state and sets max_tokens to 32.
//   The line state also clears after the byte marked end_of_line.
// Stall:
//   when dout is not taken the result holds; din keeps accepting while the input
//   register is empty, then stops until the result moves on. Nothing is dropped.
`timescale 1ns / 1ps
`default_nettype none

module quote_brace_tokenizer_top
  import qbt_pkg::*;
#(
  parameter int LINE_MAX    = LINE_MAX_DEFAULT,
  parameter int TOKEN_SLOTS = TOKEN_SLOTS_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  qbt_in_if.sink       din,
  qbt_out_if.source    dout,
  qbt_cfg_if.sink      cfg
);

  localparam int LP_W  = $clog2(LINE_MAX);
  localparam int CNT_W = $clog2(TOKEN_SLOTS + 1);

  logic [5:0]        max_tokens;

  logic              s1_valid;
  logic [7:0]        s1_char;
  logic              s1_eol;
  logic              advance;

  logic [LP_W-1:0]   line_position;
  logic [CNT_W-1:0]  token_count;
  logic              in_quote;
  logic signed [4:0] group_depth;
  logic              after_separator;

  logic [LP_W-1:0]   line_position_next;
  logic [CNT_W-1:0]  token_count_next;
  logic              in_quote_next;
  logic signed [4:0] group_depth_next;
  logic              after_separator_next;
  qbt_result_t       step_result;

  logic              out_valid;
  qbt_result_t       out_item;

  assign cfg.ready = 1'b1;

  // input item moves on when the result register is free or being drained
  assign advance   = s1_valid && (!out_valid || dout.ready);
  assign din.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_tokens <= MAX_TOKENS_RESET;
    end else if (cfg.valid && cfg.ready) begin
      max_tokens <= cfg.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (din.ready) begin
      s1_valid <= din.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (din.valid && din.ready) begin
      s1_char <= din.char_in;
      s1_eol  <= din.end_of_line;
    end
  end

  qbt_step #(
    .LINE_MAX    (LINE_MAX),
    .TOKEN_SLOTS (TOKEN_SLOTS)
  ) u_step (
    .char_in              (s1_char),
    .end_of_line          (s1_eol),
    .max_tokens           (max_tokens),
    .line_position        (line_position),
    .token_count          (token_count),
    .in_quote             (in_quote),
    .group_depth          (group_depth),
    .after_separator      (after_separator),
    .line_position_next   (line_position_next),
    .token_count_next     (token_count_next),
    .in_quote_next        (in_quote_next),
    .group_depth_next     (group_depth_next),
    .after_separator_next (after_separator_next),
    .result               (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      line_position   <= '0;
      token_count     <= '0;
      in_quote        <= 1'b0;
      group_depth     <= 5'sd0;
      after_separator <= 1'b1;
    end else if (advance) begin
      line_position   <= line_position_next;
      token_count     <= token_count_next;
      in_quote        <= in_quote_next;
      group_depth     <= group_depth_next;
      after_separator <= after_separator_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (dout.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= step_result;
    end
  end

  assign dout.valid          = out_valid;
  assign dout.out_byte       = out_item.out_byte;
  assign dout.token_start    = out_item.token_start;
  assign dout.token_position = out_item.token_position;
  assign dout.token_slot     = out_item.token_slot;
  assign dout.table_full     = out_item.table_full;

endmodule

`default_nettype wire

// File: sv/qbt_step.sv
// qbt_step: combinational tokenizer step, current line state and one byte in,
// next line state and result item out; depends on qbt_pkg
`timescale 1ns / 1ps
`default_nettype none

module qbt_step
  import qbt_pkg::*;
#(
  parameter int LINE_MAX    = LINE_MAX_DEFAULT,
  parameter int TOKEN_SLOTS = TOKEN_SLOTS_DEFAULT,
  localparam int LP_W  = $clog2(LINE_MAX),
  localparam int CNT_W = $clog2(TOKEN_SLOTS + 1)
) (
  input  logic              [7:0]       char_in,
  input  logic                          end_of_line,
  input  logic              [5:0]       max_tokens,
  input  logic              [LP_W-1:0]  line_position,
  input  logic              [CNT_W-1:0] token_count,
  input  logic                          in_quote,
  input  logic signed       [4:0]       group_depth,
  input  logic                          after_separator,
  output logic              [LP_W-1:0]  line_position_next,
  output logic              [CNT_W-1:0] token_count_next,
  output logic                          in_quote_next,
  output logic signed       [4:0]       group_depth_next,
  output logic                          after_separator_next,
  output qbt_result_t                   result
);

  localparam int POS_W  = LP_W + 1;
  localparam int EXT_W  = (POS_W > 8) ? POS_W : 8;
  localparam int CMP_W  = (CNT_W > 7) ? CNT_W : 7;
  localparam int SLOT_W = (CNT_W > 5) ? CNT_W : 5;
  localparam logic [CMP_W-1:0] SLOTS_C  = CMP_W'(TOKEN_SLOTS);
  localparam logic [LP_W-1:0]  POS_LAST = LP_W'(LINE_MAX - 1);

  logic signed [4:0]  depth_dec;
  logic [CMP_W-1:0]   mt_ext;
  logic [CMP_W-1:0]   limit;
  logic [CMP_W-1:0]   cnt_ext;
  logic               want_start;
  logic [POS_W-1:0]   start_pos;
  logic [EXT_W-1:0]   pos_ext;
  logic [SLOT_W-1:0]  slot_ext;
  logic               slot_free;

  assign depth_dec = (group_depth > DEPTH_MIN) ? group_depth - 5'sd1 : group_depth;
  assign mt_ext    = CMP_W'(max_tokens);
  assign limit     = (mt_ext < SLOTS_C) ? mt_ext : SLOTS_C;
  assign cnt_ext   = CMP_W'(token_count);
  assign slot_free = cnt_ext < limit;
  assign pos_ext   = EXT_W'(start_pos);
  assign slot_ext  = SLOT_W'(token_count);

  always_comb begin
    in_quote_next        = in_quote;
    group_depth_next     = group_depth;
    after_separator_next = after_separator;
    want_start           = 1'b0;
    start_pos            = POS_W'(line_position);
    result.out_byte      = char_in;

    if (char_in == CH_QUOTE) begin
      in_quote_next = !in_quote;
      // closing quote terminates the token
      if (in_quote) begin
        result.out_byte      = 8'd0;
        after_separator_next = 1'b1;
      end
    end else if ((char_in inside {CH_LBRACE, CH_RBRACE}) && !in_quote) begin
      if (char_in == CH_LBRACE) begin
        // outermost group starts a token just past the brace
        if (group_depth == 5'sd0) begin
          after_separator_next = 1'b0;
          want_start           = 1'b1;
          start_pos            = POS_W'(line_position) + POS_W'(1);
        end
        if (group_depth < DEPTH_MAX) begin
          group_depth_next = group_depth + 5'sd1;
        end
      end else begin
        group_depth_next = depth_dec;
        if (depth_dec == 5'sd0) begin
          result.out_byte      = 8'd0;
          after_separator_next = 1'b1;
        end
      end
    end else if ((char_in inside {CH_SPACE, CH_TAB}) && !in_quote
                 && group_depth == 5'sd0) begin
      result.out_byte      = 8'd0;
      after_separator_next = 1'b1;
    end else if (after_separator) begin
      after_separator_next = 1'b0;
      want_start           = 1'b1;
    end

    result.token_start    = want_start && slot_free;
    result.table_full     = want_start && !slot_free;
    result.token_position = result.token_start ? pos_ext[7:0] : 8'd0;
    result.token_slot     = result.token_start ? slot_ext[4:0] : 5'd0;
    token_count_next      = result.token_start ? token_count + CNT_W'(1) : token_count;

    line_position_next = (line_position < POS_LAST) ? line_position + LP_W'(1)
                                                    : line_position;

    if (end_of_line) begin
      line_position_next   = '0;
      token_count_next     = '0;
      in_quote_next        = 1'b0;
      group_depth_next     = 5'sd0;
      after_separator_next = 1'b1;
    end
  end

endmodule

`default_nettype wire
